>>> design/lapr_pkg.sv
// Shared types, constants and the next-generation cell function for the packed Life row stream.
package lapr_pkg;

  localparam int CELLS_W      = 32;
  localparam int ROW_IDX_W    = 14;
  localparam int WORD_IDX_W   = 9;
  localparam int WIDTH_REG_W  = 10;
  localparam int HEIGHT_REG_W = 15;
  localparam int CFG_DATA_W   = 15;
  localparam int CFG_IDX_W    = 1;
  localparam int OUT_TDATA_W  = 56;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 10'd512;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 15'd16384;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef logic [CELLS_W-1:0]    cells_t;
  typedef logic [ROW_IDX_W-1:0]  row_idx_t;
  typedef logic [WORD_IDX_W-1:0] word_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_WORDS = 1'b0,
    CFG_HEIGHT_ROWS = 1'b1
  } lapr_cfg_e;

  typedef enum logic {
    REQ_GRID  = 1'b0,
    REQ_DRAIN = 1'b1
  } lapr_req_e;

  // One classified word handed from the front to the back.
  // col_w[0] row above (r-2), col_w[1] own row (r-1), col_w[2] row below (r).
  typedef struct packed {
    logic [2:0][CELLS_W-1:0] col_w;
    logic                    row_start;
    logic                    emit_a;
    logic                    emit_b;
    logic                    frame_end;
    row_idx_t                row_idx;
    word_idx_t               word_idx;
  } lapr_item_t;

  // B3/S23 over one word; index k: 0 above, 1 own, 2 below.
  function automatic cells_t life_word(input logic [2:0][CELLS_W-1:0] lw,
                                       input logic [2:0][CELLS_W-1:0] cw,
                                       input logic [2:0][CELLS_W-1:0] rw);
    logic [2:0][CELLS_W+1:0] ext;
    logic [3:0]              cnt;
    cells_t                  res;
    for (int k = 0; k < 3; k++) begin
      ext[k] = {rw[k][0], cw[k], lw[k][CELLS_W-1]};
    end
    for (int i = 0; i < CELLS_W; i++) begin
      cnt = 4'(ext[0][i]) + 4'(ext[0][i+1]) + 4'(ext[0][i+2])
          + 4'(ext[1][i]) + 4'(ext[1][i+2])
          + 4'(ext[2][i]) + 4'(ext[2][i+1]) + 4'(ext[2][i+2]);
      res[i] = (cnt == 4'd3) || (ext[1][i+1] && (cnt == 4'd2));
    end
    return res;
  endfunction

endpackage

>>> design/life_automaton_packed_row_stream.sv
// Top level of the packed-row Life generation stream.
//
// Input beats (s_axis_*) carry one 32-cell grid word in raster order, or a
// drain word (tuser high) once the last row is in. One row of drain words
// flushes the final grid row. Results (m_axis_*) give the next generation of
// the row above, one word behind the input; the last word of a row gives two
// results, a one-word row gives one per word, and the first row gives none.
// tlast marks the final word of the generation. Beats of the wrong kind for
// the current position are taken and dropped.
// One beat per cycle is taken while s_axis_tready is high. A result passes the
// front end registers, the queue and the back end window; the second result of
// a row end follows the first. The extra result is absorbed by a four-entry
// queue after the classifying front end; rows over one word stall input when full.
// The line buffers are one 512x64 memory, one read and one write per cycle.
// When m_axis_tready is low results wait in the output register and the queue
// fills, after which s_axis_tready falls. Reset sets width 512 words, height
// 16384 rows and position zero; a register write also restarts the frame.
// Line buffer contents are undefined after reset but never read before use.
module life_automaton_packed_row_stream #(
  parameter int MAX_ROW_WORDS = 512,
  parameter int MAX_ROWS      = 16384
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [31:0]                            s_axis_tdata,  // cells
  input  logic                                   s_axis_tuser,  // req_type
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // next_cells [31:0], row_index [45:32], word_index [54:46], zero [55]
  output logic [lapr_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                   m_axis_tlast,  // frame_last
  input  logic                                   cfg_we_i,
  input  logic [lapr_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [lapr_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  logic                                 push, pop, q_valid;
  lapr_pkg::lapr_item_t                 push_item, head_item;
  logic [lapr_pkg::QUEUE_CNT_W-1:0]     q_count;
  lapr_pkg::cells_t                     res_cells;
  lapr_pkg::row_idx_t                   res_row;
  lapr_pkg::word_idx_t                  res_word;

  lapr_front #(
    .MAX_ROW_WORDS (MAX_ROW_WORDS),
    .MAX_ROWS      (MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_drain_i  (s_axis_tuser == lapr_pkg::REQ_DRAIN),
    .s_cells_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_count_i  (q_count),
    .push_o     (push),
    .item_o     (push_item)
  );

  lapr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item),
    .count_o (q_count)
  );

  lapr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .item_i    (head_item),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cells_o   (res_cells),
    .row_o     (res_row),
    .word_o    (res_word),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, res_word, res_row, res_cells};

endmodule

>>> design/lapr_front.sv
// Front end: accepts beats, tracks row and word position, runs the line buffers, classifies words.
module lapr_front #(
  parameter int MAX_ROW_WORDS = 512,
  parameter int MAX_ROWS      = 16384
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_valid_i,
  output logic                                  s_ready_o,
  input  logic                                  s_drain_i,
  input  lapr_pkg::cells_t                      s_cells_i,
  input  logic                                  cfg_we_i,
  input  logic [lapr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [lapr_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic [lapr_pkg::QUEUE_CNT_W-1:0]      q_count_i,
  output logic                                  push_o,
  output lapr_pkg::lapr_item_t                  item_o
);

  localparam int CW = $clog2(MAX_ROW_WORDS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int AW = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
  localparam int MW = 2 * lapr_pkg::CELLS_W;

  logic [lapr_pkg::WIDTH_REG_W-1:0]  width_q;
  logic [lapr_pkg::HEIGHT_REG_W-1:0] height_q;
  logic [CW-1:0] word_q, word_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] eff_w, c_eff;
  logic [RW-1:0] eff_h, r_eff, row_m1;
  logic          restart, last_col, at_drain_row, accept, process;
  logic [lapr_pkg::QUEUE_CNT_W:0] used;

  // line buffer: low half row r-2, high half row r-1
  logic [MW-1:0] lbuf_mem [MAX_ROW_WORDS];
  logic [MW-1:0] rd_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [MW-1:0] wr_data;

  logic                b_valid_q, b_drain_q, b_ge1_q, b_ge2_q;
  logic                b_start_q, b_emit_a_q, b_emit_b_q, b_end_q;
  lapr_pkg::cells_t    b_cells_q;
  logic [AW-1:0]       b_addr_q;
  lapr_pkg::row_idx_t  b_row_q;
  lapr_pkg::word_idx_t b_word_q;

  always_comb begin
    if (width_q == '0) begin
      eff_w = CW'(1);
    end else if (width_q > MAX_ROW_WORDS) begin
      eff_w = CW'(MAX_ROW_WORDS);
    end else begin
      eff_w = CW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = RW'(1);
    end else if (height_q > MAX_ROWS) begin
      eff_h = RW'(MAX_ROWS);
    end else begin
      eff_h = RW'(height_q);
    end
  end

  assign restart      = (word_q >= eff_w) || (row_q > eff_h);
  assign c_eff        = restart ? '0 : word_q;
  assign r_eff        = restart ? '0 : row_q;
  assign row_m1       = r_eff - RW'(1);
  assign last_col     = (c_eff == (eff_w - CW'(1)));
  assign at_drain_row = (r_eff == eff_h);

  // credit check: the word in flight plus the queue fill must leave a slot
  assign used      = (lapr_pkg::QUEUE_CNT_W + 1)'(q_count_i)
                   + (lapr_pkg::QUEUE_CNT_W + 1)'(b_valid_q);
  assign s_ready_o = (used < lapr_pkg::QUEUE_DEPTH);
  assign accept    = s_valid_i && s_ready_o;
  assign process   = accept && (s_drain_i == at_drain_row);

  always_comb begin
    word_d = word_q;
    row_d  = row_q;
    if (cfg_we_i) begin
      word_d = '0;
      row_d  = '0;
    end else if (accept) begin
      word_d = c_eff;
      row_d  = r_eff;
      if (process) begin
        if (last_col) begin
          word_d = '0;
          row_d  = at_drain_row ? '0 : r_eff + RW'(1);
        end else begin
          word_d = c_eff + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= lapr_pkg::WIDTH_RESET;
      height_q  <= lapr_pkg::HEIGHT_RESET;
      word_q    <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      word_q    <= word_d;
      row_q     <= row_d;
      b_valid_q <= process;
      if (cfg_we_i) begin
        case (lapr_pkg::lapr_cfg_e'(cfg_idx_i))
          lapr_pkg::CFG_WIDTH_WORDS: width_q  <= cfg_data_i[lapr_pkg::WIDTH_REG_W-1:0];
          lapr_pkg::CFG_HEIGHT_ROWS: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      b_drain_q  <= s_drain_i;
      b_cells_q  <= s_cells_i;
      b_addr_q   <= rd_addr;
      b_ge1_q    <= (r_eff >= RW'(1));
      b_ge2_q    <= (r_eff >= RW'(2));
      b_start_q  <= (c_eff == '0);
      b_emit_a_q <= (r_eff >= RW'(1)) && (c_eff != '0);
      b_emit_b_q <= (r_eff >= RW'(1)) && last_col;
      b_end_q    <= at_drain_row;
      b_row_q    <= lapr_pkg::row_idx_t'(row_m1);
      b_word_q   <= lapr_pkg::word_idx_t'(c_eff);
    end
  end

  assign rd_addr = c_eff[AW-1:0];
  assign wr_en   = b_valid_q && !b_drain_q;
  assign wr_addr = b_addr_q;
  assign wr_data = {b_cells_q, rd_q[MW-1:lapr_pkg::CELLS_W]};

  // the previous word may write the address read now when a row is one word long
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lbuf_mem[wr_addr] <= wr_data;
    end
    if (process) begin
      rd_q <= (wr_en && (wr_addr == rd_addr)) ? wr_data : lbuf_mem[rd_addr];
    end
  end

  always_comb begin
    push_o             = b_valid_q;
    item_o.col_w[0]    = b_ge2_q ? rd_q[lapr_pkg::CELLS_W-1:0] : '0;
    item_o.col_w[1]    = b_ge1_q ? rd_q[MW-1:lapr_pkg::CELLS_W] : '0;
    item_o.col_w[2]    = b_drain_q ? '0 : b_cells_q;
    item_o.row_start   = b_start_q;
    item_o.emit_a      = b_emit_a_q;
    item_o.emit_b      = b_emit_b_q;
    item_o.frame_end   = b_end_q;
    item_o.row_idx     = b_row_q;
    item_o.word_idx    = b_word_q;
  end

`ifndef SYNTHESIS
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (q_count_i < lapr_pkg::QUEUE_DEPTH))
    else $error("front pushed into a full queue");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cfg_we_i) |-> (word_q == '0) && (row_q == '0))
    else $error("register write did not restart the frame");
`endif

endmodule

>>> design/lapr_queue.sv
// Short queue between the front and back ends.
module lapr_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  lapr_pkg::lapr_item_t              item_i,
  input  logic                              pop_i,
  output logic                              valid_o,
  output lapr_pkg::lapr_item_t              item_o,
  output logic [lapr_pkg::QUEUE_CNT_W-1:0]  count_o
);

  lapr_pkg::lapr_item_t                 slot_q [lapr_pkg::QUEUE_DEPTH];
  logic [lapr_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [lapr_pkg::QUEUE_CNT_W-1:0]     count_q;
  logic                                 do_pop;

  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + lapr_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + lapr_pkg::QUEUE_PTR_W'(1);
      end
      count_q <= count_q + lapr_pkg::QUEUE_CNT_W'(push_i)
                         - lapr_pkg::QUEUE_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < lapr_pkg::QUEUE_DEPTH))
    else $error("queue overflow");
`endif

endmodule

>>> design/lapr_back.sv
// Back end: slides the 3x3 word window and issues up to two next-generation words per item.
module lapr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  lapr_pkg::lapr_item_t  item_i,
  output logic                  pop_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output lapr_pkg::cells_t      cells_o,
  output lapr_pkg::row_idx_t    row_o,
  output lapr_pkg::word_idx_t   word_o,
  output logic                  last_o
);

  // win_q[col][row]: col 0 left, 1 centre, 2 right
  logic [2:0][2:0][lapr_pkg::CELLS_W-1:0] win_q;
  logic                pend_a_q, pend_b_q, pend_a_d, pend_b_d;
  logic                end_q;
  lapr_pkg::row_idx_t  row_q;
  lapr_pkg::word_idx_t word_q;

  logic                m_valid_q, m_last_q;
  lapr_pkg::cells_t    m_cells_q;
  lapr_pkg::row_idx_t  m_row_q;
  lapr_pkg::word_idx_t m_word_q;

  logic pend_any, out_free, take, sel_a;
  logic [2:0][lapr_pkg::CELLS_W-1:0] lw, cw, rw;

  assign pend_any = pend_a_q || pend_b_q;
  assign out_free = !m_valid_q || m_ready_i;
  assign take     = out_free && pend_any;
  assign sel_a    = pend_a_q;
  // take the next item once the current one has issued its last word
  assign pop_o    = valid_i && (!pend_any || (take && !(pend_a_q && pend_b_q)));

  always_comb begin
    if (sel_a) begin
      lw = win_q[0];
      cw = win_q[1];
      rw = win_q[2];
    end else begin
      lw = win_q[1];
      cw = win_q[2];
      rw = '0;
    end
  end

  always_comb begin
    pend_a_d = pend_a_q && !(take && sel_a);
    pend_b_d = pend_b_q && !(take && !sel_a);
    if (pop_o) begin
      pend_a_d = item_i.emit_a;
      pend_b_d = item_i.emit_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_a_q  <= 1'b0;
      pend_b_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      pend_a_q <= pend_a_d;
      pend_b_q <= pend_b_d;
      if (take) begin
        m_valid_q <= 1'b1;
      end else if (out_free) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      // clear at row start: left edge of the grid is dead
      win_q[0] <= item_i.row_start ? '0 : win_q[1];
      win_q[1] <= item_i.row_start ? '0 : win_q[2];
      win_q[2] <= item_i.col_w;
      end_q    <= item_i.frame_end;
      row_q    <= item_i.row_idx;
      word_q   <= item_i.word_idx;
    end
    if (take) begin
      m_cells_q <= lapr_pkg::life_word(lw, cw, rw);
      m_row_q   <= row_q;
      m_word_q  <= sel_a ? word_q - lapr_pkg::word_idx_t'(1) : word_q;
      m_last_q  <= !sel_a && end_q;
    end
  end

  assign m_valid_o = m_valid_q;
  assign cells_o   = m_cells_q;
  assign row_o     = m_row_q;
  assign word_o    = m_word_q;
  assign last_o    = m_last_q;

`ifndef SYNTHESIS
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && pend_a_q && pend_b_q |=> pend_b_q && !pend_a_q)
    else $error("second word of a row end not kept after the first");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_any && !out_free |=> $stable(pend_a_q) && $stable(pend_b_q))
    else $error("pending words changed while output stalled");

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_last_q |-> (m_row_q == $past(row_q)) || !$past(take))
    else $error("frame end flag on an unexpected word");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for the packed-row Life generation stream.
`timescale 1ns / 100ps

module testbench;

  localparam int SETTLE_CYCLES = 16;
  localparam int LINE_WORDS    = 512;
  localparam int ROWS_CAP      = 16384;

  typedef struct packed {
    lapr_pkg::cells_t    cells;
    lapr_pkg::row_idx_t  row;
    lapr_pkg::word_idx_t word;
    logic                last;
  } gen_word_t;

  logic                                  clk_i         = 1'b0;
  logic                                  rst_ni        = 1'b0;
  logic                                  s_axis_tvalid = 1'b0;
  logic                                  s_axis_tready;
  logic [31:0]                           s_axis_tdata  = '0;
  logic                                  s_axis_tuser  = 1'b0;
  logic                                  m_axis_tvalid;
  logic                                  m_axis_tready = 1'b0;
  logic [lapr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata;
  logic                                  m_axis_tlast;
  logic                                  cfg_we_i      = 1'b0;
  logic [lapr_pkg::CFG_IDX_W-1:0]        cfg_idx_i     = '0;
  logic [lapr_pkg::CFG_DATA_W-1:0]       cfg_data_i    = '0;

  // Generation predictor state
  lapr_pkg::cells_t                      two_up_line [LINE_WORDS];
  lapr_pkg::cells_t                      one_up_line [LINE_WORDS];
  lapr_pkg::cells_t                      win [3][3];  // [row: r-2, r-1, r][col: w-2, w-1, w]
  int unsigned                           row_pos     = 0;
  int unsigned                           word_pos    = 0;
  logic [lapr_pkg::WIDTH_REG_W-1:0]      width_cfg   = lapr_pkg::WIDTH_RESET;
  logic [lapr_pkg::HEIGHT_REG_W-1:0]     height_cfg  = lapr_pkg::HEIGHT_RESET;
  gen_word_t                             words_due [$];

  int                                    fail_count  = 0;
  bit                                    tx_idle_en  = 1'b1;
  bit                                    rx_idle_en  = 1'b1;
  int                                    rx_hold_req = 0;

  life_automaton_packed_row_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin : clock_gen
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #1600000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned row_words();
    if (width_cfg == 0) return 1;
    if (width_cfg > LINE_WORDS) return LINE_WORDS;
    return int'(width_cfg);
  endfunction

  function automatic int unsigned grid_rows();
    if (height_cfg == 0) return 1;
    if (height_cfg > ROWS_CAP) return ROWS_CAP;
    return int'(height_cfg);
  endfunction

  function automatic void restart_frame();
    row_pos  = 0;
    word_pos = 0;
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++) win[k][j] = '0;
  endfunction

  // B3/S23 using the full 3x3 sum: 3 gives life, 4 keeps the centre as it is.
  function automatic lapr_pkg::cells_t life_next(
      input logic [2:0][lapr_pkg::CELLS_W-1:0] lft,
      input logic [2:0][lapr_pkg::CELLS_W-1:0] mid,
      input logic [2:0][lapr_pkg::CELLS_W-1:0] rgt);
    logic [lapr_pkg::CELLS_W+1:0] band [3];
    lapr_pkg::cells_t             born;
    int                           total;
    for (int k = 0; k < 3; k++) band[k] = {rgt[k][0], mid[k], lft[k][lapr_pkg::CELLS_W-1]};
    for (int i = 0; i < lapr_pkg::CELLS_W; i++) begin
      total = 0;
      for (int k = 0; k < 3; k++)
        for (int d = 0; d < 3; d++) total += band[k][i+d];
      born[i] = (total == 3) || ((total == 4) && band[1][i+1]);
    end
    return born;
  endfunction

  function automatic void push_word(input lapr_pkg::cells_t cells, input int unsigned r,
                                    input int unsigned c, input logic last);
    gen_word_t g;
    g.cells = cells;
    g.row   = lapr_pkg::row_idx_t'(r);
    g.word  = lapr_pkg::word_idx_t'(c);
    g.last  = last;
    words_due.push_back(g);
  endfunction

  function automatic void predict_generation(input lapr_pkg::lapr_req_e kind,
                                             input lapr_pkg::cells_t cells);
    int unsigned                       w, h, r, c;
    logic [2:0][lapr_pkg::CELLS_W-1:0] col_a, col_b, col_c, dead;
    w = row_words();
    h = grid_rows();
    if (word_pos >= w || row_pos > h) restart_frame();
    r = row_pos;
    c = word_pos;
    // drop beats of the wrong kind for this position
    if ((kind == lapr_pkg::REQ_DRAIN) != (r == h)) return;
    if (c == 0) begin
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) win[k][j] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = (r >= 2) ? two_up_line[c] : '0;
    win[1][2] = (r >= 1) ? one_up_line[c] : '0;
    win[2][2] = (kind == lapr_pkg::REQ_DRAIN) ? '0 : cells;
    if (kind == lapr_pkg::REQ_GRID) begin
      two_up_line[c] = one_up_line[c];
      one_up_line[c] = cells;
    end
    if (r >= 1) begin
      dead = '0;
      for (int k = 0; k < 3; k++) begin
        col_a[k] = win[k][0];
        col_b[k] = win[k][1];
        col_c[k] = win[k][2];
      end
      if (c >= 1) push_word(life_next(col_a, col_b, col_c), r - 1, c - 1, 1'b0);
      if (c == w - 1) push_word(life_next(col_b, col_c, dead), r - 1, c, r == h);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r > h) r = 0;
    end
    row_pos  = r;
    word_pos = c;
  endfunction

  function automatic lapr_pkg::lapr_req_e proper_kind();
    if (word_pos < row_words() && row_pos == grid_rows()) return lapr_pkg::REQ_DRAIN;
    return lapr_pkg::REQ_GRID;
  endfunction

  function automatic lapr_pkg::cells_t rand_cells();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom & $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  // Valid is lowered only when a gap follows, so it never toggles within one step.
  task automatic send_beat(input lapr_pkg::lapr_req_e kind, input lapr_pkg::cells_t cells);
    int gap;
    gap = tx_idle_en ? $urandom_range(12, 0) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= cells;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_generation(kind, cells);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input lapr_pkg::lapr_cfg_e idx,
                           input logic [lapr_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == lapr_pkg::CFG_WIDTH_WORDS) width_cfg = data[lapr_pkg::WIDTH_REG_W-1:0];
    else height_cfg = data[lapr_pkg::HEIGHT_REG_W-1:0];
    restart_frame();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_proper(input int n);
    repeat (n) send_beat(proper_kind(), rand_cells());
  endtask

  // Reset values: position zero and long rows, so the first row gives nothing.
  task automatic test_reset_defaults();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_proper(16);
  endtask

  task automatic test_directed();
    wait_idle();
    cfg_write(lapr_pkg::CFG_WIDTH_WORDS, 15'h7C03);  // upper bits fall outside the register
    cfg_write(lapr_pkg::CFG_HEIGHT_ROWS, 15'h0002);
    send_beat(lapr_pkg::REQ_GRID,  32'hFFFF_FFFF);
    send_beat(lapr_pkg::REQ_DRAIN, 32'h1234_5678);   // drain during grid rows: dropped
    send_beat(lapr_pkg::REQ_GRID,  32'h0000_0000);
    send_beat(lapr_pkg::REQ_GRID,  32'h8000_0001);
    send_beat(lapr_pkg::REQ_GRID,  32'h0000_0007);
    send_beat(lapr_pkg::REQ_GRID,  32'hFFFF_FFFF);
    send_beat(lapr_pkg::REQ_GRID,  32'h0000_0001);
    send_beat(lapr_pkg::REQ_GRID,  32'hDEAD_BEEF);   // grid word during drain row: dropped
    send_beat(lapr_pkg::REQ_DRAIN, 32'hFFFF_FFFF);
    send_beat(lapr_pkg::REQ_DRAIN, 32'h0000_0000);
    send_beat(lapr_pkg::REQ_DRAIN, 32'hAAAA_5555);
    // next frame starts again at row zero
    send_beat(lapr_pkg::REQ_GRID,  32'h8000_0000);
    send_beat(lapr_pkg::REQ_GRID,  32'h0000_0001);
    send_beat(lapr_pkg::REQ_GRID,  32'h0000_0000);
    send_beat(lapr_pkg::REQ_GRID,  32'h0001_C000);
    wait_idle();
    cfg_write(lapr_pkg::CFG_WIDTH_WORDS, 15'h0000);  // clamps to one word per row
    cfg_write(lapr_pkg::CFG_HEIGHT_ROWS, 15'h0001);
    send_beat(lapr_pkg::REQ_GRID,  32'hFFFF_FFFF);
    send_beat(lapr_pkg::REQ_DRAIN, 32'h0000_0000);
    send_beat(lapr_pkg::REQ_GRID,  32'h0000_000E);
    send_beat(lapr_pkg::REQ_GRID,  32'h0000_0001);   // grid word during drain row: dropped
    send_beat(lapr_pkg::REQ_DRAIN, 32'hFFFF_FFFF);
    send_beat(lapr_pkg::REQ_GRID,  32'h7000_0007);
  endtask

  // Full first row at the widest width, then the start of the drain row.
  task automatic test_widest_row();
    wait_idle();
    cfg_write(lapr_pkg::CFG_WIDTH_WORDS, 15'h7FFF);  // 1023 clamps to 512
    cfg_write(lapr_pkg::CFG_HEIGHT_ROWS, 15'h0000);  // clamps to one row
    send_proper(LINE_WORDS + 5);
  endtask

  task automatic test_tallest_grid();
    int n;
    wait_idle();
    cfg_write(lapr_pkg::CFG_WIDTH_WORDS, 15'h0002);
    cfg_write(lapr_pkg::CFG_HEIGHT_ROWS, 15'h7FFF);  // clamps to 16384
    for (n = 0; n < 30; n++) begin
      if (n % 7 == 3) send_beat(lapr_pkg::REQ_DRAIN, rand_cells());
      else send_beat(proper_kind(), rand_cells());
    end
  endtask

  // Hold the receiver off while the sender streams without gaps.
  task automatic test_backpressure();
    wait_idle();
    cfg_write(lapr_pkg::CFG_WIDTH_WORDS, 15'h0008);
    cfg_write(lapr_pkg::CFG_HEIGHT_ROWS, 15'h0014);
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = 200;
    send_proper(30);
  endtask

  task automatic test_random_phases();
    int                                n;
    lapr_pkg::lapr_req_e               kind;
    logic [lapr_pkg::CFG_DATA_W-1:0]   w, h;
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      tx_idle_en = (p % 3) != 0;
      rx_idle_en = (p % 4) != 1;
      w = ($urandom_range(7, 0) == 0) ? lapr_pkg::CFG_DATA_W'($urandom_range(40, 9))
                                       : lapr_pkg::CFG_DATA_W'($urandom_range(6, 0));
      h = lapr_pkg::CFG_DATA_W'($urandom_range(5, 0));
      cfg_write(lapr_pkg::CFG_WIDTH_WORDS, w);
      cfg_write(lapr_pkg::CFG_HEIGHT_ROWS, h);
      n = $urandom_range(10, 4);
      repeat (n) begin
        kind = proper_kind();
        if ($urandom_range(9, 0) == 0) begin
          kind = (kind == lapr_pkg::REQ_GRID) ? lapr_pkg::REQ_DRAIN : lapr_pkg::REQ_GRID;
        end
        send_beat(kind, rand_cells());
      end
    end
  endtask

  // Result side: stall per beat, take any requested long hold, check in order.
  initial begin : result_checker
    int        stall;
    gen_word_t want;
    forever begin
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall = rx_idle_en ? $urandom_range(12, 0) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (words_due.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = words_due.pop_front();
        if (m_axis_tdata[31:0] !== want.cells) begin
          $error("next_cells: expected %h, got %h", want.cells, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[45:32] !== want.row) begin
          $error("row_index: expected %0d, got %0d", want.row, m_axis_tdata[45:32]);
          fail_count++;
        end
        if (m_axis_tdata[54:46] !== want.word) begin
          $error("word_index: expected %0d, got %0d", want.word, m_axis_tdata[54:46]);
          fail_count++;
        end
        if (m_axis_tdata[55] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_axis_tdata[55]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("frame_last: expected %b, got %b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin : main_seq
    for (int i = 0; i < LINE_WORDS; i++) begin
      two_up_line[i] = '0;
      one_up_line[i] = '0;
    end
    restart_frame();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_widest_row();
    test_tallest_grid();
    test_backpressure();
    test_random_phases();
    wait_idle();
    if (words_due.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
